>>> hdl/plr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette retint package
// Shared constants, codes and constant-coefficient helpers for the palette
// luminance retint unit.
// ----------------------------------------------------------------------------
package plr_pkg;

    localparam int PLR_PALETTE_DEPTH = 256;

    localparam int PLR_CH_W    = 8;
    localparam int PLR_IDX_W   = 11;
    localparam int PLR_SUM_W   = 18;
    localparam int PLR_RATIO_W = 16;
    localparam int PLR_PROD_W  = 24;
    localparam int PLR_WORD_W  = 32;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_RETINT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [2:0] CFG_REF_RED    = 3'd0;
    localparam logic [2:0] CFG_REF_GREEN  = 3'd1;
    localparam logic [2:0] CFG_REF_BLUE   = 3'd2;
    localparam logic [2:0] CFG_TINT_RED   = 3'd3;
    localparam logic [2:0] CFG_TINT_GREEN = 3'd4;
    localparam logic [2:0] CFG_TINT_BLUE  = 3'd5;

    // Reciprocal constants: x/1000 = ((x>>3)*33555)>>22 for x < 2^18,
    // and z/255 = (z*65794)>>24 for z < 2^16.
    localparam logic [15:0] DIV1000_MUL = 16'd33555;
    localparam logic [16:0] DIV255_MUL  = 17'd65794;
    localparam logic [PLR_PROD_W-1:0] SAT_LIMIT = 24'd65280;

    function automatic logic [PLR_SUM_W-1:0] plr_wsum(
        input logic [PLR_CH_W-1:0] r,
        input logic [PLR_CH_W-1:0] g,
        input logic [PLR_CH_W-1:0] b
    );
        return PLR_SUM_W'(r) * 18'd299 + PLR_SUM_W'(g) * 18'd587
             + PLR_SUM_W'(b) * 18'd114;
    endfunction

    function automatic logic [PLR_CH_W-1:0] plr_div1000(
        input logic [PLR_SUM_W-1:0] x
    );
        logic [14:0] y;
        logic [30:0] p;
        y = x[17:3];
        p = 31'(y) * 31'(DIV1000_MUL);
        return p[29:22];
    endfunction

endpackage
`default_nettype wire

>>> hdl/plr_palette_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette memory
// Single write port, single registered read port holding the RGBA entries.
// ----------------------------------------------------------------------------
module plr_palette_mem
    import plr_pkg::*;
#(
    parameter int PALETTE_DEPTH = PLR_PALETTE_DEPTH,
    parameter int AW            = $clog2(PALETTE_DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [PLR_WORD_W-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [PLR_WORD_W-1:0] o_rdata
);

    logic [PLR_WORD_W-1:0] r_mem [PALETTE_DEPTH];
    logic [PLR_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/plr_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ratio divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plr_divider
    import plr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [PLR_RATIO_W-1:0] i_dividend,
    input  wire logic [PLR_CH_W-1:0]    i_divisor,
    output logic                        o_done,
    output logic      [PLR_RATIO_W-1:0] o_quotient
);

    localparam int CW = $clog2(PLR_RATIO_W);

    logic                   r_busy;
    logic [CW-1:0]          r_cnt;
    logic [PLR_CH_W-1:0]    r_divisor;
    logic [PLR_CH_W-1:0]    r_rem;
    logic [PLR_RATIO_W-1:0] r_quo;
    logic [PLR_CH_W:0]      trial;
    logic                   take;

    assign trial = {r_rem, r_quo[PLR_RATIO_W-1]};
    assign take  = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(PLR_RATIO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= take ? PLR_CH_W'(trial - {1'b0, r_divisor}) : trial[PLR_CH_W-1:0];
            r_quo <= {r_quo[PLR_RATIO_W-2:0], take};
        end
    end

    assign o_done     = r_busy && (r_cnt == CW'(PLR_RATIO_W - 1));
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

>>> hdl/plr_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Channel scaler
// Two-stage unit shared by the three channels: tint times ratio, then a
// saturating divide by 255 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module plr_scale
    import plr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic [PLR_CH_W-1:0]    i_tint,
    input  wire logic [PLR_RATIO_W-1:0] i_ratio,
    output logic      [PLR_CH_W-1:0]    o_chan
);

    logic [PLR_PROD_W-1:0] r_prod;
    logic [PLR_CH_W-1:0]   r_chan;
    logic [32:0]           recip;

    assign recip = 33'(r_prod[15:0]) * 33'(DIV255_MUL);

    always_ff @(posedge i_clk) begin
        r_prod <= PLR_PROD_W'(i_tint) * PLR_PROD_W'(i_ratio);
        if (r_prod >= SAT_LIMIT) begin
            r_chan <= '1;
        end else begin
            r_chan <= recip[31:24];
        end
    end

    assign o_chan = r_chan;

endmodule
`default_nettype wire

>>> hdl/palette_luminance_retint_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette luminance retint unit
// Holds an RGBA palette and recolors entries with a tint scaled by luminance.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the action (load,
// retint, read), tdata the entry index and the load bytes, tlast a list mark.
// A load writes the entry in the cycle it is taken and gives no result.
// A read or a retint gives one result on m_axis: tdata holds entry and RGBA,
// tuser the applied flag, tlast the copied list mark. Out-of-range indexes
// give all-zero tdata and tuser.
// A read passes a memory read and an emit step, an out-of-range request only
// the emit step, and a retint a memory read, two luminance steps, divider,
// scaler, write-back and emit; a zero reference luminance skips divider,
// scaler and write-back. One request is processed at a time; s_axis_tready
// is high only in idle, so a read or retint blocks new requests until emitted.
// The result sits in an output register; while the receiver stalls the
// sequencer holds the next result and takes no new request.
// The cfg channel is always ready; the user must write it only while the unit
// is idle, which the unit does not enforce. Synchronous reset returns the
// sequencer to idle, empties the output and sets all color registers to 255.
// Palette contents are undefined until loaded; no clearing pass is done.
// ----------------------------------------------------------------------------
module palette_luminance_retint_unit
    import plr_pkg::*;
#(
    parameter int PALETTE_DEPTH = PLR_PALETTE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: entry_index[10:0], load_red[18:11], load_green[26:19],
    // load_blue[34:27], load_alpha[42:35], zero pad[47:43]
    input  wire logic [47:0] s_axis_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: entry_out[7:0], red_out[15:8], green_out[23:16],
    // blue_out[31:24], alpha_out[39:32]
    output logic      [39:0] m_axis_tdata,
    // tuser: applied[0]
    output logic      [0:0]  m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_BASE,
        S_LUMA,
        S_DIV,
        S_SCALE,
        S_WRITE,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [PLR_CH_W-1:0] r_ref_red, r_ref_green, r_ref_blue;
    logic [PLR_CH_W-1:0] r_tint_red, r_tint_green, r_tint_blue;

    logic [1:0]            r_action;
    logic [PLR_IDX_W-1:0]  r_idx;
    logic [PLR_CH_W-1:0]   r_entry;
    logic                  r_last;
    logic                  r_applied;
    logic [PLR_WORD_W-1:0] r_word;
    logic [PLR_SUM_W-1:0]  r_acc;
    logic [PLR_CH_W-1:0]   r_base;
    logic [2:0]            r_cnt;

    logic                  r_out_valid;
    logic [39:0]           r_out_data;
    logic                  r_out_applied;
    logic                  r_out_last;

    logic [1:0]            in_action;
    logic [PLR_IDX_W-1:0]  in_idx;
    logic [PLR_WORD_W-1:0] in_word;
    logic                  in_accept;
    logic                  in_valid_idx;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [PLR_WORD_W-1:0] mem_wdata;
    logic [PLR_WORD_W-1:0] mem_rdata;

    logic [PLR_CH_W-1:0]    lum;
    logic [PLR_RATIO_W-1:0] lum_x255;
    logic                   div_start;
    logic                   div_done;
    logic [PLR_RATIO_W-1:0] ratio;
    logic [PLR_CH_W-1:0]    tint_sel;
    logic [PLR_CH_W-1:0]    scaled;
    logic                   out_free;

    assign in_action    = s_axis_tuser;
    assign in_idx       = s_axis_tdata[10:0];
    assign in_word      = s_axis_tdata[42:11];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign in_valid_idx = ({1'b0, in_idx} < (PLR_IDX_W + 1)'(PALETTE_DEPTH));

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_red    <= '1;
            r_ref_green  <= '1;
            r_ref_blue   <= '1;
            r_tint_red   <= '1;
            r_tint_green <= '1;
            r_tint_blue  <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REF_RED:    r_ref_red    <= i_cfg_data;
                CFG_REF_GREEN:  r_ref_green  <= i_cfg_data;
                CFG_REF_BLUE:   r_ref_blue   <= i_cfg_data;
                CFG_TINT_RED:   r_tint_red   <= i_cfg_data;
                CFG_TINT_GREEN: r_tint_green <= i_cfg_data;
                CFG_TINT_BLUE:  r_tint_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_state == S_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = r_idx[AW-1:0];
            mem_wdata = r_word;
        end else begin
            mem_we    = in_accept && (in_action == ACT_LOAD) && in_valid_idx;
            mem_waddr = in_idx[AW-1:0];
            mem_wdata = in_word;
        end
    end

    plr_palette_mem #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .AW            (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (in_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign lum       = plr_div1000(r_acc);
    assign lum_x255  = {lum, 8'h00} - {8'h00, lum};
    assign div_start = (r_state == S_LUMA) && (r_base != '0);

    plr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lum_x255),
        .i_divisor  (r_base),
        .o_done     (div_done),
        .o_quotient (ratio)
    );

    always_comb begin
        case (r_cnt)
            3'd0:    tint_sel = r_tint_red;
            3'd1:    tint_sel = r_tint_green;
            default: tint_sel = r_tint_blue;
        endcase
    end

    plr_scale u_scale (
        .i_clk   (i_clk),
        .i_tint  (tint_sel),
        .i_ratio (ratio),
        .o_chan  (scaled)
    );

    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_action  <= in_action;
                        r_idx     <= in_idx;
                        r_last    <= s_axis_tlast;
                        r_applied <= 1'b0;
                        r_word    <= '0;
                        r_entry   <= in_valid_idx ? in_idx[PLR_CH_W-1:0] : '0;
                        if (in_action == ACT_RETINT || in_action == ACT_READ) begin
                            r_state <= in_valid_idx ? S_READ : S_EMIT;
                        end
                    end
                end
                S_READ: begin
                    r_word <= mem_rdata;
                    r_acc  <= plr_wsum(r_ref_red, r_ref_green, r_ref_blue);
                    r_state <= (r_action == ACT_RETINT) ? S_BASE : S_EMIT;
                end
                S_BASE: begin
                    r_base  <= plr_div1000(r_acc);
                    r_acc   <= plr_wsum(r_word[7:0], r_word[15:8], r_word[23:16]);
                    r_state <= S_LUMA;
                end
                S_LUMA: begin
                    r_cnt   <= '0;
                    r_state <= (r_base == '0) ? S_EMIT : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        3'd2:    r_word[7:0]   <= scaled;
                        3'd3:    r_word[15:8]  <= scaled;
                        3'd4:    r_word[23:16] <= scaled;
                        default: ;
                    endcase
                    if (r_cnt == 3'd4) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_applied <= 1'b1;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_data    <= {r_word, r_entry};
                        r_out_applied <= r_applied;
                        r_out_last    <= r_last;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_applied;
    assign m_axis_tlast    = r_out_last;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("Divider finished outside the divide step.");

    a_write_nonzero_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_base != '0)
        else $error("Retint write-back with a zero reference luminance.");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("Result appeared without passing the emit step.");

endmodule
`default_nettype wire

>>> test/palette_luminance_retint_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Palette luminance retint checker
// Watches the request, result and register channels of the retint unit. It
// keeps its own copy of the palette and of the color registers, works out the
// result of every accepted request and compares each result, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module palette_luminance_retint_checker
    import plr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [47:0] i_req_data,
    input  logic [1:0]  i_req_action,
    input  logic        i_req_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,
    input  logic        i_res_applied,
    input  logic        i_res_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] entry;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       applied;
        logic       last;
    } t_swatch_result;

    logic [PLR_WORD_W-1:0] palette_copy [PLR_PALETTE_DEPTH];
    logic [7:0]            color_reg [6];
    t_swatch_result        expected_swatches [$];
    int                    mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    initial o_pending = 0;

    function automatic int unsigned luminance(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        return (299 * int'(r) + 587 * int'(g) + 114 * int'(b)) / 1000;
    endfunction

    function automatic logic [7:0] tinted(input logic [7:0] tint, input int unsigned ratio);
        int unsigned lit;
        lit = int'(tint) * ratio / 255;
        return (lit > 255) ? 8'hFF : lit[7:0];
    endfunction

    task automatic note_field(input string name, input int expected_value,
                              input int actual_value);
        if (expected_value != actual_value) begin
            $error("%s: expected %0d, got %0d", name, expected_value, actual_value);
            mismatch_total++;
        end
    endtask

    task automatic predict_palette_step();
        logic [1:0]            action;
        logic [10:0]           index;
        logic [PLR_WORD_W-1:0] word;
        t_swatch_result        outcome;
        int unsigned           base;
        int unsigned           lum;
        int unsigned           ratio;
        bit                    in_range;
        action = i_req_action;
        index = i_req_data[10:0];
        in_range = int'(index) < PLR_PALETTE_DEPTH;
        if (action == ACT_LOAD) begin
            if (in_range) begin
                palette_copy[index[7:0]] = i_req_data[42:11];
            end
            return;
        end
        if (action != ACT_RETINT && action != ACT_READ) begin
            return;
        end
        outcome = '0;
        outcome.last = i_req_last;
        if (in_range) begin
            word = palette_copy[index[7:0]];
            if (action == ACT_RETINT) begin
                base = luminance(color_reg[CFG_REF_RED], color_reg[CFG_REF_GREEN],
                                 color_reg[CFG_REF_BLUE]);
                if (base != 0) begin
                    lum = luminance(word[7:0], word[15:8], word[23:16]);
                    ratio = lum * 255 / base;
                    word[7:0]   = tinted(color_reg[CFG_TINT_RED], ratio);
                    word[15:8]  = tinted(color_reg[CFG_TINT_GREEN], ratio);
                    word[23:16] = tinted(color_reg[CFG_TINT_BLUE], ratio);
                    palette_copy[index[7:0]] = word;
                    outcome.applied = 1'b1;
                end
            end
            outcome.entry = index[7:0];
            outcome.red   = word[7:0];
            outcome.green = word[15:8];
            outcome.blue  = word[23:16];
            outcome.alpha = word[31:24];
        end
        expected_swatches.push_back(outcome);
    endtask

    task automatic check_swatch();
        t_swatch_result want;
        if (expected_swatches.size() == 0) begin
            $error("result for entry %0d arrived with no request outstanding",
                   i_res_data[7:0]);
            mismatch_total++;
            return;
        end
        want = expected_swatches.pop_front();
        note_field("entry_out", want.entry, i_res_data[7:0]);
        note_field("red_out", want.red, i_res_data[15:8]);
        note_field("green_out", want.green, i_res_data[23:16]);
        note_field("blue_out", want.blue, i_res_data[31:24]);
        note_field("alpha_out", want.alpha, i_res_data[39:32]);
        note_field("applied", want.applied, i_res_applied);
        note_field("last_out", want.last, i_res_last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (color_reg[i]) begin
                color_reg[i] = 8'hFF;
            end
            expected_swatches.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= CFG_TINT_BLUE) begin
                color_reg[i_cfg_index] = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                check_swatch();
            end
            if (i_req_valid && i_req_ready) begin
                predict_palette_step();
            end
        end
        o_pending <= expected_swatches.size();
    end

endmodule

>>> test/palette_luminance_retint_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Palette luminance retint unit testbench
// Loads, retints and reads palette entries under several tint and reference
// settings, with random gaps on the request side and random stalls on the
// result side. A checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module palette_luminance_retint_unit_tb;
    import plr_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 155;
    localparam int PAUSE_EVERY   = 60;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_LOAD;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_REF_RED;
    logic [7:0]  i_cfg_data = '0;

    int          mismatches;
    int          pending;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_tag = 0;
    int          hold_tag_seen = 0;
    int          hold_left = 0;
    int          requests_counted = 0;
    logic [7:0]  filled_entries [$];
    bit          entry_filled [PLR_PALETTE_DEPTH];

    palette_luminance_retint_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    palette_luminance_retint_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_action  (s_axis_tuser),
        .i_req_last    (s_axis_tlast),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_applied (m_axis_tuser[0]),
        .i_res_last    (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("palette_luminance_retint_unit: mismatch");
            $finish;
        end
    end

    // A new hold tag starts a long stretch with the result side held off.
    always @(posedge i_clk) begin
        if (hold_tag != hold_tag_seen) begin
            hold_tag_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_request(input logic [1:0] action, input logic [10:0] index,
                                input logic [31:0] rgba, input logic last);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {5'b0, rgba, index};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (action == ACT_LOAD && int'(index) < PLR_PALETTE_DEPTH
                && !entry_filled[index[7:0]]) begin
            entry_filled[index[7:0]] = 1'b1;
            filled_entries.push_back(index[7:0]);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Byte i of colors goes to register i; the spare index gets random data.
    task automatic apply_colors(input logic [47:0] colors);
        logic [2:0] reg_codes [7] = '{CFG_REF_RED, CFG_REF_GREEN, CFG_REF_BLUE,
                                      CFG_TINT_RED, CFG_TINT_GREEN, CFG_TINT_BLUE,
                                      CFG_UNUSED};
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int i = 0; i < 7; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_codes[i];
            i_cfg_data  <= (i < 6) ? colors[8*i +: 8] : 8'($urandom);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_list();
        logic [1:0] act_codes [3] = '{ACT_LOAD, ACT_RETINT, ACT_READ};
        logic [1:0] action;
        logic [10:0] far_index;
        int list_len;
        int pick;
        logic last;
        list_len = $urandom_range(1, 6);
        for (int k = 0; k < list_len; k++) begin
            pick = $urandom_range(99);
            last = (k == list_len - 1) ? 1'b1 : 1'($urandom_range(9) == 0);
            far_index = {3'($urandom_range(1, 7)), 8'($urandom)};
            if (filled_entries.size() == 0 || pick < 25) begin
                send_request(ACT_LOAD, {3'b000, 8'($urandom)}, $urandom, last);
                requests_counted++;
            end else if (pick < 70) begin
                send_request(ACT_RETINT,
                             {3'b000, filled_entries[$urandom_range(filled_entries.size() - 1)]},
                             $urandom, last);
                requests_counted++;
            end else if (pick < 85) begin
                send_request(ACT_READ,
                             {3'b000, filled_entries[$urandom_range(filled_entries.size() - 1)]},
                             $urandom, last);
                requests_counted++;
            end else if (pick < 94) begin
                action = act_codes[$urandom_range(2)];
                send_request(action, far_index, $urandom, last);
                if (action != ACT_LOAD) begin
                    requests_counted++;
                end
            end else begin
                send_request(ACT_NONE, 11'($urandom), $urandom, last);
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [47:0] colors, input bit long_hold);
        int next_pause;
        apply_colors(colors);
        sender_idle_pct = idle_pct;
        receiver_stall_pct <= stall_pct;
        if (long_hold) begin
            hold_tag <= hold_tag + 1;
        end
        requests_counted = 0;
        next_pause = PAUSE_EVERY;
        while (requests_counted < PHASE_ITEMS) begin
            send_random_list();
            if (requests_counted >= next_pause) begin
                wait_drained();
                next_pause += PAUSE_EVERY;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_colors({6{8'hFF}});
        send_request(ACT_LOAD, 11'd0, 32'h0000_0000, 1'b0);
        send_request(ACT_LOAD, 11'd255, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_LOAD, 11'd17, $urandom, 1'b0);
        send_request(ACT_LOAD, 11'h7FF, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_LOAD, 11'h3FF, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_LOAD, 11'h400, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_LOAD, 11'h100, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_READ, 11'd0, 32'h0000_0000, 1'b0);
        send_request(ACT_READ, 11'd255, 32'h0000_0000, 1'b0);
        send_request(ACT_READ, 11'd17, 32'h0000_0000, 1'b1);
        send_request(ACT_READ, 11'h7FF, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_READ, 11'h100, 32'h0000_0000, 1'b0);
        send_request(ACT_NONE, 11'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_RETINT, 11'd255, 32'h0000_0000, 1'b0);
        send_request(ACT_RETINT, 11'd0, 32'h0000_0000, 1'b0);
        send_request(ACT_RETINT, 11'd17, 32'h0000_0000, 1'b1);
        send_request(ACT_RETINT, 11'h3FF, 32'h0000_0000, 1'b0);
        send_request(ACT_RETINT, 11'h400, 32'h0000_0000, 1'b1);

        // A black reference has zero luminance, so the retint must be skipped.
        apply_colors({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
        send_request(ACT_RETINT, 11'd17, 32'h0000_0000, 1'b1);

        // The smallest nonzero reference luminance drives the channels with a nonzero tint into saturation.
        apply_colors({8'd128, 8'd0, 8'd255, 8'd0, 8'd0, 8'd4});
        send_request(ACT_RETINT, 11'd255, 32'h0000_0000, 1'b0);
        send_request(ACT_RETINT, 11'd17, 32'h0000_0000, 1'b1);

        run_phase(0, 0, {8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom)}, 1'b1);
        run_phase(53, 0, {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        run_phase(0, 53, {8'hFF, 8'hFF, 8'hFF, 8'($urandom_range(15)),
                          8'($urandom_range(15)), 8'($urandom_range(15))}, 1'b0);
        run_phase(27, 27, {8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom)}, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("palette_luminance_retint_unit: match");
        end else begin
            $display("palette_luminance_retint_unit: mismatch");
        end
        $finish;
    end

endmodule
